// ===== src/uart_pkg.sv =====
// ----------------------------------------------------------------------------
// uart_pkg: shared types and constants for the 8N1 transceiver
// Register map, reset values, receive status codes and receiver phases.
// ----------------------------------------------------------------------------
`default_nettype none

package uart_pkg;

  // Configuration register widths and reset values
  localparam int unsigned CPB_W       = 20;
  localparam int unsigned TMO_W       = 32;
  localparam logic [CPB_W-1:0] CPB_RESET = 20'd6076;
  localparam logic [TMO_W-1:0] TMO_RESET = 32'd70000000;

  // APB side
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam logic        REG_CPB     = 1'b0;
  localparam logic        REG_TMO     = 1'b1;

  // Frame format
  localparam int unsigned DATA_BITS_DEF = 8;
  localparam int unsigned BYTE_W        = 8;

  // Receive status codes
  localparam logic [1:0] RX_OK       = 2'd0;
  localparam logic [1:0] RX_TIMEOUT  = 2'd1;
  localparam logic [1:0] RX_BAD_STOP = 2'd2;

  // Receiver phases
  typedef enum logic [1:0] {
    RX_IDLE = 2'd0,
    RX_WAIT = 2'd1,
    RX_DATA = 2'd2,
    RX_STOP = 2'd3
  } rx_phase_t;

endpackage

`default_nettype wire

// ===== src/uart_8n1_transceiver.sv =====
// ----------------------------------------------------------------------------
// uart_8n1_transceiver: 8N1 serial transmitter and receiver
// Each input transaction is one tick of the line timebase; each tick yields
// one result transaction with the pin level and receive status.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one tick: tx_start, tx_byte,
//   the sampled rx_line level and rx_request. Result channel
//   (out_valid/out_ready) returns one transaction per tick: tx_line, tx_busy,
//   rx_busy, rx_done, rx_status and rx_byte.
//   A tick accepted at one edge sits in the input register; once the
//   result register is free, the frame/receive state updates and the
//   result register loads at the same edge, and out_valid rises.
//   Throughput is one tick per cycle while the result side is not stalled.
//   If the result side stalls, the result register holds and the input
//   register takes one more tick; after that in_ready drops until out_ready
//   returns. No tick is dropped or repeated.
//   Reset (rst_n low, synchronous) empties both registers, idles both the
//   transmitter and receiver and loads cycles_per_bit = 6076 and
//   rx_timeout_cycles = 70000000. Registers are written over the APB port
//   (offset 0x0 cycles_per_bit, 0x4 rx_timeout_cycles); the user must write
//   them only while no tick is in flight, which the block does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_8n1_transceiver #(
  parameter int unsigned DATA_BITS = uart_pkg::DATA_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input channel
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             in_tx_start,
  input  wire logic [uart_pkg::BYTE_W-1:0]      in_tx_byte,
  input  wire logic                             in_rx_line,
  input  wire logic                             in_rx_request,
  // result channel
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_tx_line,
  output logic                                  out_tx_busy,
  output logic                                  out_rx_busy,
  output logic                                  out_rx_done,
  output logic [1:0]                            out_rx_status,
  output logic [uart_pkg::BYTE_W-1:0]           out_rx_byte,
  // configuration port
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [uart_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [uart_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [uart_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                  pready
);

  localparam int unsigned FRAME_W = DATA_BITS + 2;
  localparam int unsigned BLEFT_W = $clog2(FRAME_W + 1);
  localparam int unsigned BIDX_W  = $clog2(DATA_BITS + 1);
  localparam int unsigned CPB_W   = uart_pkg::CPB_W;
  localparam int unsigned TMO_W   = uart_pkg::TMO_W;
  localparam logic [BLEFT_W-1:0] FRAME_BITS = BLEFT_W'(FRAME_W);
  localparam logic [BIDX_W-1:0]  LAST_IDX   = BIDX_W'(DATA_BITS);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CPB_W-1:0] cpb_r;
  logic [TMO_W-1:0] tmo_r;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpb_r <= uart_pkg::CPB_RESET;
      tmo_r <= uart_pkg::TMO_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        uart_pkg::REG_CPB: cpb_r <= pwdata[CPB_W-1:0];
        uart_pkg::REG_TMO: tmo_r <= pwdata[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (paddr[2])
      uart_pkg::REG_CPB: prdata = {{(uart_pkg::APB_DATA_W-CPB_W){1'b0}}, cpb_r};
      uart_pkg::REG_TMO: prdata = tmo_r;
      default:           prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline control: input register -> state update -> result register
  // --------------------------------------------------------------------------
  logic                    in_valid_r;
  logic                    tx_start_r;
  logic [uart_pkg::BYTE_W-1:0] tx_byte_r;
  logic                    rx_line_r;
  logic                    rx_req_r;
  logic                    out_valid_r;
  logic                    out_load;
  logic                    in_load;

  assign out_load = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || out_load;
  assign in_load  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      tx_start_r <= in_tx_start;
      tx_byte_r  <= in_tx_byte;
      rx_line_r  <= in_rx_line;
      rx_req_r   <= in_rx_request;
    end
  end

  // Effective bit period: zero reads as one
  logic [CPB_W-1:0] bit_n;
  assign bit_n = (cpb_r == '0) ? CPB_W'(1) : cpb_r;

  // --------------------------------------------------------------------------
  // Transmitter
  // --------------------------------------------------------------------------
  logic [FRAME_W-1:0] tx_shift_r,  tx_shift_nxt,  tx_shift_a;
  logic [BLEFT_W-1:0] tx_left_r,   tx_left_nxt,   tx_left_a;
  logic [CPB_W-1:0]   tx_timer_r,  tx_timer_nxt,  tx_timer_a;
  logic [CPB_W:0]     tx_timer_inc;
  logic               tx_go;
  logic [DATA_BITS+uart_pkg::BYTE_W-1:0] tx_byte_ext;
  logic               tx_line_c, tx_busy_c;

  assign tx_go       = (tx_left_r == '0) && tx_start_r;
  assign tx_byte_ext = {{DATA_BITS{1'b0}}, tx_byte_r};

  // load a new frame, then hold each bit for one bit period
  always_comb begin
    tx_shift_a   = tx_go ? {1'b1, tx_byte_ext[DATA_BITS-1:0], 1'b0} : tx_shift_r;
    tx_left_a    = tx_go ? FRAME_BITS : tx_left_r;
    tx_timer_a   = tx_go ? '0 : tx_timer_r;
    tx_timer_inc = {1'b0, tx_timer_a} + (CPB_W+1)'(1);
    tx_shift_nxt = tx_shift_a;
    tx_left_nxt  = tx_left_a;
    tx_timer_nxt = tx_timer_a;
    tx_line_c    = 1'b1;
    tx_busy_c    = 1'b0;
    if (tx_left_a != '0) begin
      tx_line_c = tx_shift_a[0];
      tx_busy_c = 1'b1;
      if (tx_timer_inc >= {1'b0, bit_n}) begin
        tx_timer_nxt = '0;
        tx_shift_nxt = {1'b1, tx_shift_a[FRAME_W-1:1]};
        tx_left_nxt  = tx_left_a - BLEFT_W'(1);
      end else begin
        tx_timer_nxt = tx_timer_inc[CPB_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_shift_r <= '1;
      tx_left_r  <= '0;
      tx_timer_r <= '0;
    end else if (out_load) begin
      tx_shift_r <= tx_shift_nxt;
      tx_left_r  <= tx_left_nxt;
      tx_timer_r <= tx_timer_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver next state
  // --------------------------------------------------------------------------
  uart_pkg::rx_phase_t rx_phase_r, rx_phase_nxt, rx_phase_a;
  logic [TMO_W-1:0]    rx_timer_r, rx_timer_nxt, rx_timer_a;
  logic [BIDX_W-1:0]   rx_idx_r,   rx_idx_nxt;
  logic [DATA_BITS-1:0] rx_data_r, rx_data_nxt;
  logic [TMO_W-1:0]    rx_timer_inc, rx_timer_dec, rx_stop_inc;
  logic [CPB_W:0]      half_plus_n;
  logic                rx_done_c;
  logic [1:0]          rx_status_c;

  assign half_plus_n = {1'b0, bit_n >> 1} + {1'b0, bit_n};

  always_comb begin
    rx_phase_a   = (rx_phase_r == uart_pkg::RX_IDLE && rx_req_r) ?
                   uart_pkg::RX_WAIT : rx_phase_r;
    rx_timer_a   = (rx_phase_r == uart_pkg::RX_IDLE && rx_req_r) ? '0 : rx_timer_r;
    rx_timer_inc = rx_timer_a + TMO_W'(1);
    rx_timer_dec = rx_timer_a - TMO_W'(1);
    rx_phase_nxt = rx_phase_a;
    rx_timer_nxt = rx_timer_a;
    rx_idx_nxt   = rx_idx_r;
    rx_data_nxt  = rx_data_r;
    rx_done_c    = 1'b0;
    rx_status_c  = uart_pkg::RX_OK;

    case (rx_phase_a)
      // waiting for the start edge
      uart_pkg::RX_WAIT: begin
        if (!rx_line_r) begin
          rx_phase_nxt = uart_pkg::RX_DATA;
          rx_timer_nxt = {{(TMO_W-CPB_W-1){1'b0}}, half_plus_n};
          rx_idx_nxt   = '0;
          rx_data_nxt  = '0;
        end else begin
          rx_timer_nxt = rx_timer_inc;
          if (rx_timer_inc >= tmo_r) begin
            rx_phase_nxt = uart_pkg::RX_IDLE;
            rx_done_c    = 1'b1;
            rx_status_c  = uart_pkg::RX_TIMEOUT;
          end
        end
      end
      // mid-bit sampling
      uart_pkg::RX_DATA: begin
        rx_timer_nxt = rx_timer_dec;
        if (rx_timer_dec == '0) begin
          if (rx_idx_r >= LAST_IDX) begin
            rx_phase_nxt = uart_pkg::RX_STOP;
          end else begin
            for (int i = 0; i < DATA_BITS; i++) begin
              if (rx_idx_r == BIDX_W'(i)) rx_data_nxt[i] = rx_line_r;
            end
            rx_idx_nxt   = rx_idx_r + BIDX_W'(1);
            rx_timer_nxt = {{(TMO_W-CPB_W){1'b0}}, bit_n};
          end
        end
      end
      default: ;
    endcase

    // stop window, checked on the tick it opens as well
    rx_stop_inc = rx_timer_nxt + TMO_W'(1);
    if (rx_phase_nxt == uart_pkg::RX_STOP) begin
      if (rx_line_r) begin
        rx_phase_nxt = uart_pkg::RX_IDLE;
        rx_done_c    = 1'b1;
        rx_status_c  = uart_pkg::RX_OK;
      end else begin
        rx_timer_nxt = rx_stop_inc;
        if (rx_stop_inc >= {{(TMO_W-CPB_W){1'b0}}, bit_n}) begin
          rx_phase_nxt = uart_pkg::RX_IDLE;
          rx_done_c    = 1'b1;
          rx_status_c  = uart_pkg::RX_BAD_STOP;
        end
      end
    end
  end

  // entering the stop window restarts its timer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_phase_r <= uart_pkg::RX_IDLE;
      rx_timer_r <= '0;
      rx_idx_r   <= '0;
      rx_data_r  <= '0;
    end else if (out_load) begin
      rx_phase_r <= rx_phase_nxt;
      rx_timer_r <= rx_timer_nxt;
      rx_idx_r   <= rx_idx_nxt;
      rx_data_r  <= rx_data_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver outputs
  // --------------------------------------------------------------------------
  logic [DATA_BITS+uart_pkg::BYTE_W-1:0] rx_data_ext;
  logic [uart_pkg::BYTE_W-1:0]           rx_byte_c;
  logic                                  rx_busy_c;

  assign rx_data_ext = {{uart_pkg::BYTE_W{1'b0}}, rx_data_r};

  always_comb begin
    rx_busy_c = (rx_phase_nxt != uart_pkg::RX_IDLE);
    rx_byte_c = '0;
    if (rx_done_c && rx_status_c == uart_pkg::RX_OK) begin
      rx_byte_c = rx_data_ext[uart_pkg::BYTE_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic                        res_tx_line_r, res_tx_busy_r, res_rx_busy_r, res_rx_done_r;
  logic [1:0]                  res_rx_status_r;
  logic [uart_pkg::BYTE_W-1:0] res_rx_byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_tx_line_r   <= tx_line_c;
      res_tx_busy_r   <= tx_busy_c;
      res_rx_busy_r   <= rx_busy_c;
      res_rx_done_r   <= rx_done_c;
      res_rx_status_r <= rx_status_c;
      res_rx_byte_r   <= rx_byte_c;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_tx_line   = res_tx_line_r;
  assign out_tx_busy   = res_tx_busy_r;
  assign out_rx_busy   = res_rx_busy_r;
  assign out_rx_done   = res_rx_done_r;
  assign out_rx_status = res_rx_status_r;
  assign out_rx_byte   = res_rx_byte_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_tx_idle_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_tx_busy_r |-> res_tx_line_r)
    else $error("tx line low while transmitter idle");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_rx_done_r |-> !res_rx_busy_r)
    else $error("receive done while still busy");

  a_status_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_rx_status_r != uart_pkg::RX_OK |-> res_rx_done_r)
    else $error("receive status without done");

  a_byte_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_rx_byte_r != '0 |->
      res_rx_done_r && res_rx_status_r == uart_pkg::RX_OK)
    else $error("received byte shown without good completion");

  a_tx_left_range: assert property (@(posedge clk) disable iff (!rst_n)
    tx_left_r <= FRAME_BITS)
    else $error("transmit bit count out of range");

  a_state_frozen_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_load |=> $stable(rx_phase_r) && $stable(tx_left_r))
    else $error("state advanced without a transaction moving forward");

endmodule

`default_nettype wire
